// ===== src/rtt_pkg.sv =====
package rtt_pkg;

   // register reset value and result limits
   localparam logic [31:0] MIN_INTERVAL_RESET = 32'd50;
   localparam logic [4:0]  MAX_ITEMS          = 5'd16;
   localparam logic [4:0]  ONE_ITEM           = 5'd1;

   typedef enum logic [2:0] {
      ACT_ADD        = 3'd0,
      ACT_REMOVE     = 3'd1,
      ACT_REMOVE_ALL = 3'd2,
      ACT_RESTART    = 3'd3,
      ACT_TICK       = 3'd4,
      ACT_LIST       = 3'd5,
      ACT_EXISTS     = 3'd6
   } action_type;

   typedef enum logic [2:0] {
      KIND_ADDED    = 3'd0,
      KIND_REJECTED = 3'd1,
      KIND_DONE     = 3'd2,
      KIND_FIRED    = 3'd3,
      KIND_LISTED   = 3'd4,
      KIND_EXISTS   = 3'd5,
      KIND_NONE     = 3'd6
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE    = 3'd0,
      ST_DECODE  = 3'd1,
      ST_SCAN    = 3'd2,
      ST_RESTART = 3'd3,
      ST_FINISH  = 3'd4
   } state_type;

   // one timer slot as kept in the slot memory; due is start plus delay
   typedef struct packed {
      logic [15:0] repeats;
      logic [31:0] delay;
      logic [31:0] due;
   } entry_type;

   typedef struct packed {
      logic load;
      logic decode;
      logic scan;
      logic restart;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic go_scan;
      logic go_restart;
      logic scan_done;
      logic out_free;
   } status_type;

endpackage

// ===== src/rtt_channels.sv =====
interface rtt_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [3:0]  slot;
   logic [31:0] now;
   logic [31:0] delay;
   logic [15:0] repeat_count;
   logic [31:0] window;

   modport source (
      output valid, action, slot, now, delay, repeat_count, window,
      input  ready
   );
   modport sink (
      input  valid, action, slot, now, delay, repeat_count, window,
      output ready
   );
endinterface

interface rtt_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  result_kind;
   logic [3:0]  result_slot;
   logic        found;
   logic [31:0] time_left;
   logic        last;

   modport source (
      output valid, result_kind, result_slot, found, time_left, last,
      input  ready
   );
   modport sink (
      input  valid, result_kind, result_slot, found, time_left, last,
      output ready
   );
endinterface

// ===== src/rtt_ctrl.sv =====
module rtt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  rtt_pkg::status_type  status,
   output rtt_pkg::cmd_type     cmd
);

   rtt_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rtt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rtt_pkg::ST_IDLE: begin
            if (req_valid) state_in = rtt_pkg::ST_DECODE;
         end
         rtt_pkg::ST_DECODE: begin
            if (status.go_scan) state_in = rtt_pkg::ST_SCAN;
            else if (status.go_restart) state_in = rtt_pkg::ST_RESTART;
            else state_in = rtt_pkg::ST_FINISH;
         end
         rtt_pkg::ST_SCAN: begin
            if (status.scan_done) state_in = rtt_pkg::ST_FINISH;
         end
         rtt_pkg::ST_RESTART: begin
            state_in = rtt_pkg::ST_FINISH;
         end
         rtt_pkg::ST_FINISH: begin
            if (status.out_free) state_in = rtt_pkg::ST_IDLE;
         end
         default: begin
            state_in = rtt_pkg::ST_IDLE;
         end
      endcase
   end

   // commands to the datapath
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         rtt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         rtt_pkg::ST_DECODE: begin
            cmd.decode = 1'b1;
         end
         rtt_pkg::ST_SCAN: begin
            cmd.scan = ~status.scan_done;
         end
         rtt_pkg::ST_RESTART: begin
            cmd.restart = 1'b1;
         end
         rtt_pkg::ST_FINISH: begin
            cmd.finish = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== src/rtt_datapath.sv =====
module rtt_datapath #(
   parameter int NUM_TIMERS = 16
) (
   input  logic                clock,
   input  logic                reset,
   // register write
   input  logic                csr_wr_en,
   input  logic [31:0]         csr_wr_data,
   // request payload
   input  logic [2:0]          action,
   input  logic [3:0]          slot,
   input  logic [31:0]         now,
   input  logic [31:0]         delay,
   input  logic [15:0]         repeat_count,
   input  logic [31:0]         window,
   // result register
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [2:0]          result_kind,
   output logic [3:0]          result_slot,
   output logic                found,
   output logic [31:0]         time_left,
   output logic                last,
   // controller link
   input  rtt_pkg::cmd_type    cmd,
   output rtt_pkg::status_type status
);

   localparam int IDXW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CNTW = $clog2(NUM_TIMERS + 1);
   localparam logic [CNTW-1:0] END_CNT = CNTW'(NUM_TIMERS);

   // request and register storage
   logic [31:0] min_interval_ff;
   logic [2:0]  op_ff;
   logic [3:0]  slot_ff;
   logic [31:0] now_ff, delay_ff, window_ff;
   logic [15:0] reps_ff;

   // slot table
   logic [NUM_TIMERS-1:0] valid_ff, valid_in;
   rtt_pkg::entry_type    mem_ff [NUM_TIMERS];
   rtt_pkg::entry_type    rd_data_ff;
   logic                  rd_en, wr_en;
   logic [IDXW-1:0]       rd_addr, wr_addr;
   rtt_pkg::entry_type    wr_data;

   // scan pipeline
   logic [CNTW-1:0] iss_ff, iss_in;
   logic            b_valid_ff, b_valid_in;
   logic [IDXW-1:0] b_idx_ff, b_idx_in;
   logic            b_live_ff, b_live_in;
   logic [4:0]      hits_ff, hits_in;

   // pending result, held until it is known whether it is the last
   logic              pend_valid_ff, pend_valid_in;
   rtt_pkg::kind_type pend_kind_ff, pend_kind_in;
   logic [3:0]        pend_slot_ff, pend_slot_in;
   logic              pend_found_ff, pend_found_in;
   logic [31:0]       pend_left_ff, pend_left_in;

   // result register
   logic              out_valid_ff, out_valid_in;
   rtt_pkg::kind_type out_kind_ff, out_kind_in;
   logic [3:0]        out_slot_ff, out_slot_in;
   logic              out_found_ff, out_found_in;
   logic [31:0]       out_left_ff, out_left_in;
   logic              out_last_ff, out_last_in;

   // decode helpers
   rtt_pkg::action_type op;
   logic            in_range, slot_live, short_delay, out_free;
   logic [IDXW-1:0] slot_idx, iss_idx;
   logic [31:0]     add_due, re_due, left;
   logic            tick_hit, list_hit, cand, hit, stall, advance, take, go_scan;
   logic [4:0]      limit;
   logic [15:0]     reps_dec;

   assign op          = rtt_pkg::action_type'(op_ff);
   assign in_range    = {28'd0, slot_ff} < 32'(NUM_TIMERS);
   assign slot_idx    = IDXW'(slot_ff);
   assign iss_idx     = iss_ff[IDXW-1:0];
   assign slot_live   = in_range && valid_ff[slot_idx];
   assign short_delay = delay_ff < min_interval_ff;
   assign out_free    = ~out_valid_ff | rsp_ready;

   // slot arithmetic: one add or subtract and one compare each
   assign add_due  = now_ff + delay_ff;
   assign re_due   = now_ff + rd_data_ff.delay;
   assign left     = rd_data_ff.due - now_ff;
   assign tick_hit = now_ff >= rd_data_ff.due;
   assign list_hit = (window_ff == 32'd0) || (left <= window_ff);
   assign reps_dec = (rd_data_ff.repeats == 16'd0) ? 16'd0 : rd_data_ff.repeats - 16'd1;

   // add stops at the first free slot, tick and list at the item limit
   assign limit = (op == rtt_pkg::ACT_ADD) ? rtt_pkg::ONE_ITEM : rtt_pkg::MAX_ITEMS;

   always_comb begin
      case (op)
         rtt_pkg::ACT_ADD:  cand = ~b_live_ff;
         rtt_pkg::ACT_TICK: cand = b_live_ff && tick_hit;
         rtt_pkg::ACT_LIST: cand = b_live_ff && list_hit;
         default:           cand = 1'b0;
      endcase
   end

   assign hit     = cmd.scan && b_valid_ff && (hits_ff != limit) && cand;
   assign stall   = hit && pend_valid_ff && ~out_free;
   assign advance = cmd.scan && ~stall;
   assign take    = hit && ~stall;
   assign go_scan = ((op == rtt_pkg::ACT_ADD) && ~short_delay) ||
                    (op == rtt_pkg::ACT_TICK) || (op == rtt_pkg::ACT_LIST);

   assign status.go_scan    = go_scan;
   assign status.go_restart = (op == rtt_pkg::ACT_RESTART) && slot_live;
   assign status.scan_done  = (hits_ff == limit) || ((iss_ff == END_CNT) && ~b_valid_ff);
   assign status.out_free   = out_free;

   // next values of table, scan, pending and result registers
   always_comb begin
      valid_in      = valid_ff;
      rd_en         = 1'b0;
      rd_addr       = iss_idx;
      wr_en         = 1'b0;
      wr_addr       = b_idx_ff;
      wr_data       = rd_data_ff;
      iss_in        = iss_ff;
      b_valid_in    = b_valid_ff;
      b_idx_in      = b_idx_ff;
      b_live_in     = b_live_ff;
      hits_in       = hits_ff;
      pend_valid_in = pend_valid_ff;
      pend_kind_in  = pend_kind_ff;
      pend_slot_in  = pend_slot_ff;
      pend_found_in = pend_found_ff;
      pend_left_in  = pend_left_ff;
      out_valid_in  = out_valid_ff & ~rsp_ready;
      out_kind_in   = out_kind_ff;
      out_slot_in   = out_slot_ff;
      out_found_in  = out_found_ff;
      out_left_in   = out_left_ff;
      out_last_in   = out_last_ff;

      // new request
      if (cmd.load) begin
         iss_in        = '0;
         b_valid_in    = 1'b0;
         hits_in       = '0;
         pend_valid_in = 1'b0;
      end

      // single-result actions
      if (cmd.decode && ~go_scan) begin
         pend_valid_in = 1'b1;
         pend_kind_in  = rtt_pkg::KIND_DONE;
         pend_slot_in  = 4'd0;
         pend_found_in = 1'b0;
         pend_left_in  = 32'd0;
         case (op)
            rtt_pkg::ACT_ADD: begin
               pend_kind_in = rtt_pkg::KIND_REJECTED;
            end
            rtt_pkg::ACT_REMOVE: begin
               if (in_range) valid_in[slot_idx] = 1'b0;
            end
            rtt_pkg::ACT_REMOVE_ALL: begin
               valid_in = '0;
            end
            rtt_pkg::ACT_RESTART: begin
               rd_en   = slot_live;
               rd_addr = slot_idx;
            end
            rtt_pkg::ACT_EXISTS: begin
               pend_kind_in  = rtt_pkg::KIND_EXISTS;
               pend_found_in = slot_live;
            end
            default: begin
               pend_kind_in = rtt_pkg::KIND_DONE;
            end
         endcase
      end

      // restart write-back: start moves to now
      if (cmd.restart) begin
         wr_en       = 1'b1;
         wr_addr     = slot_idx;
         wr_data.due = re_due;
      end

      // scan issue stage
      if (advance) begin
         if (iss_ff != END_CNT) begin
            rd_en      = 1'b1;
            rd_addr    = iss_idx;
            b_valid_in = 1'b1;
            b_idx_in   = iss_idx;
            b_live_in  = valid_ff[iss_idx];
            iss_in     = iss_ff + CNTW'(1);
         end else begin
            b_valid_in = 1'b0;
         end
      end

      // scan evaluate stage
      if (take) begin
         hits_in       = hits_ff + 5'd1;
         pend_valid_in = 1'b1;
         pend_slot_in  = 4'(b_idx_ff);
         pend_found_in = 1'b0;
         pend_left_in  = 32'd0;
         if (pend_valid_ff) begin
            out_valid_in = 1'b1;
            out_kind_in  = pend_kind_ff;
            out_slot_in  = pend_slot_ff;
            out_found_in = pend_found_ff;
            out_left_in  = pend_left_ff;
            out_last_in  = 1'b0;
         end
         case (op)
            rtt_pkg::ACT_ADD: begin
               pend_kind_in       = rtt_pkg::KIND_ADDED;
               valid_in[b_idx_ff] = 1'b1;
               wr_en              = 1'b1;
               wr_data.repeats    = reps_ff;
               wr_data.delay      = delay_ff;
               wr_data.due        = add_due;
            end
            rtt_pkg::ACT_TICK: begin
               pend_kind_in = rtt_pkg::KIND_FIRED;
               if (rd_data_ff.repeats == 16'd1) begin
                  valid_in[b_idx_ff] = 1'b0;
               end else begin
                  wr_en           = 1'b1;
                  wr_data.repeats = reps_dec;
                  wr_data.due     = re_due;
               end
            end
            default: begin
               pend_kind_in = rtt_pkg::KIND_LISTED;
               pend_left_in = left;
            end
         endcase
      end

      // final result, marked last
      if (cmd.finish) begin
         pend_valid_in = 1'b0;
         out_valid_in  = 1'b1;
         out_last_in   = 1'b1;
         if (pend_valid_ff) begin
            out_kind_in  = pend_kind_ff;
            out_slot_in  = pend_slot_ff;
            out_found_in = pend_found_ff;
            out_left_in  = pend_left_ff;
         end else begin
            out_kind_in  = (op == rtt_pkg::ACT_ADD) ? rtt_pkg::KIND_REJECTED
                                                    : rtt_pkg::KIND_NONE;
            out_slot_in  = 4'd0;
            out_found_in = 1'b0;
            out_left_in  = 32'd0;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_interval_ff <= rtt_pkg::MIN_INTERVAL_RESET;
         valid_ff        <= '0;
         iss_ff          <= '0;
         b_valid_ff      <= 1'b0;
         hits_ff         <= '0;
         pend_valid_ff   <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) min_interval_ff <= csr_wr_data;
         valid_ff      <= valid_in;
         iss_ff        <= iss_in;
         b_valid_ff    <= b_valid_in;
         hits_ff       <= hits_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= action;
         slot_ff   <= slot;
         now_ff    <= now;
         delay_ff  <= delay;
         reps_ff   <= repeat_count;
         window_ff <= window;
      end
      b_idx_ff      <= b_idx_in;
      b_live_ff     <= b_live_in;
      pend_kind_ff  <= pend_kind_in;
      pend_slot_ff  <= pend_slot_in;
      pend_found_ff <= pend_found_in;
      pend_left_ff  <= pend_left_in;
      out_kind_ff   <= out_kind_in;
      out_slot_ff   <= out_slot_in;
      out_found_ff  <= out_found_in;
      out_left_ff   <= out_left_in;
      out_last_ff   <= out_last_in;
   end

   // slot memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rsp_valid   = out_valid_ff;
   assign result_kind = out_kind_ff;
   assign result_slot = out_slot_ff;
   assign found       = out_found_ff;
   assign time_left   = out_left_ff;
   assign last        = out_last_ff;

endmodule

// ===== src/repeating_timer_table_top.sv =====
// channel   dir  handshake          carries
// req_chan  in   valid/ready        action, slot, now, delay, repeat_count, window
// rsp_chan  out  valid/ready        result_kind, result_slot, found, time_left, last
// csr_      in   csr_wr_en          csr_wr_data -> min_interval
//
// one request in work at a time; the states that each request passes through:
// add with a short delay, remove, remove all, exists, restart of a free slot: decode, finish;
//    restart of a live slot: decode, restart, finish
// tick, list and a rejected add walk every slot through a two-stage scan (read,
//    evaluate); an add that takes slot k ends its scan there
// a stalled result output holds the scan while a further result is found
// synchronous reset clears all slots and sets min_interval to 50; no clearing pass
module repeating_timer_table_top #(
   parameter int NUM_TIMERS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   rtt_req_if.sink     req_chan,
   rtt_rsp_if.source   rsp_chan
);

   rtt_pkg::cmd_type    cmd;
   rtt_pkg::status_type status;

   // sequencer
   rtt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // slot table and scan
   rtt_datapath #(
      .NUM_TIMERS (NUM_TIMERS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .action       (req_chan.action),
      .slot         (req_chan.slot),
      .now          (req_chan.now),
      .delay        (req_chan.delay),
      .repeat_count (req_chan.repeat_count),
      .window       (req_chan.window),
      .rsp_ready    (rsp_chan.ready),
      .rsp_valid    (rsp_chan.valid),
      .result_kind  (rsp_chan.result_kind),
      .result_slot  (rsp_chan.result_slot),
      .found        (rsp_chan.found),
      .time_left    (rsp_chan.time_left),
      .last         (rsp_chan.last),
      .cmd          (cmd),
      .status       (status)
   );

endmodule

// ===== src/rtt_checker.sv =====
module rtt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_kind,
   input logic [3:0]  rsp_slot,
   input logic        rsp_found,
   input logic [31:0] rsp_time_left,
   input logic        rsp_last
);

   // a waiting result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // a waiting result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_kind) && $stable(rsp_slot) && $stable(rsp_found) &&
         $stable(rsp_time_left) && $stable(rsp_last))
      else $error("result changed while stalled");

   // one request at a time: ready drops right after a request is taken
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in work");

   // only tick and list produce more than one result
   a_multi_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |->
         rsp_kind == rtt_pkg::KIND_FIRED || rsp_kind == rtt_pkg::KIND_LISTED)
      else $error("unexpected non-final result kind");

endmodule

bind repeating_timer_table_top rtt_checker u_rtt_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_kind      (rsp_chan.result_kind),
   .rsp_slot      (rsp_chan.result_slot),
   .rsp_found     (rsp_chan.found),
   .rsp_time_left (rsp_chan.time_left),
   .rsp_last      (rsp_chan.last)
);
